### sv/tsp_pkg.sv
// Package for the TLV stream parser: parse phase and result kind codes,
// register indexes and the result beat type. No dependencies.
package tsp_pkg;

    // Number of bytes in a record's field id (1 or 2).
    localparam int ID_BYTES = 2;
    localparam int ID_CNT_W = $clog2(ID_BYTES + 1);

    // Field widths of one result beat.
    localparam int FIELD_ID_W  = 16;
    localparam int VALUE_LEN_W = 32;
    localparam int OFFSET_W    = 33;
    localparam int REG_W       = 32;

    // Length group number at which a set continuation bit is an overflow.
    localparam logic [2:0] LEN_LAST_GROUP = 3'd4;

    // APB address width and register indexes (decoded from paddr[2]).
    localparam int APB_ADDR_W = 3;
    localparam logic REG_BASE_OFFSET   = 1'b0;
    localparam logic REG_REGION_LENGTH = 1'b1;

    // Parse phase, one-hot.
    typedef enum logic [4:0] {
        PH_ID   = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_SKIP = 5'b00100,
        PH_END  = 5'b01000,
        PH_ERR  = 5'b10000
    } phase_t;

    // Kind of a result beat.
    typedef enum logic [1:0] {
        RK_HEADER     = 2'd0,
        RK_OVERFLOW   = 2'd1,
        RK_REGION_END = 2'd2
    } result_kind_t;

    // One result beat.
    typedef struct packed {
        result_kind_t             result_kind;
        logic [FIELD_ID_W-1:0]    field_id;
        logic [VALUE_LEN_W-1:0]   value_length;
        logic [OFFSET_W-1:0]      value_offset;
        logic                     region_done;
    } result_t;

endpackage

### sv/tsp_core.sv
// Parser core of the TLV stream parser: holds the parse state and turns one
// accepted byte into the next state and at most one result beat.
// Depends on tsp_pkg.
module tsp_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         byte_fire,
    input  logic [7:0]                   data_byte,
    input  logic [tsp_pkg::REG_W-1:0]    base_offset,
    input  logic [tsp_pkg::REG_W-1:0]    region_length,
    output logic                         emit,
    output tsp_pkg::result_t             result
);

    tsp_pkg::phase_t                          phase_reg, phase_next;
    logic [tsp_pkg::ID_CNT_W-1:0]             id_cnt_reg, id_cnt_next;
    logic [tsp_pkg::FIELD_ID_W-1:0]           id_acc_reg, id_acc_next;
    logic [tsp_pkg::VALUE_LEN_W-1:0]          len_acc_reg, len_acc_next;
    logic [2:0]                               len_grp_reg, len_grp_next;
    logic [tsp_pkg::VALUE_LEN_W-1:0]          skip_reg, skip_next;
    logic [tsp_pkg::OFFSET_W-1:0]             pos_reg, pos_next;

    logic                                     in_region;
    logic                                     active;
    logic                                     last;
    logic [tsp_pkg::OFFSET_W-1:0]             pos_inc;
    logic [tsp_pkg::OFFSET_W-1:0]             rl_ext;
    logic [2:0]                               grp_clamp;
    logic [4:0]                               len_shamt;
    logic [tsp_pkg::VALUE_LEN_W-1:0]          len_part;
    logic [tsp_pkg::VALUE_LEN_W-1:0]          len_acc_new;
    logic [tsp_pkg::ID_CNT_W-1:0]             id_cnt_inc;
    logic [tsp_pkg::VALUE_LEN_W-1:0]          skip_dec;

    // Region bookkeeping: a byte counts only below the region's length.
    assign rl_ext    = {1'b0, region_length};
    assign pos_inc   = pos_reg + tsp_pkg::OFFSET_W'(1);
    assign in_region = pos_reg < rl_ext;
    assign last      = pos_inc == rl_ext;
    assign active    = byte_fire && in_region &&
                       (phase_reg == tsp_pkg::PH_ID || phase_reg == tsp_pkg::PH_LEN ||
                        phase_reg == tsp_pkg::PH_SKIP);

    // LEB128 group placement; groups past the fifth stay at the fifth.
    assign grp_clamp   = (len_grp_reg > tsp_pkg::LEN_LAST_GROUP) ?
                         tsp_pkg::LEN_LAST_GROUP : len_grp_reg;
    assign len_shamt   = 5'(grp_clamp) * 5'd7;
    assign len_part    = {25'd0, data_byte[6:0]} << len_shamt;
    assign len_acc_new = len_acc_reg | len_part;

    assign id_cnt_inc = id_cnt_reg + tsp_pkg::ID_CNT_W'(1);
    assign skip_dec   = skip_reg - tsp_pkg::VALUE_LEN_W'(1);

    // Next state and result for one byte.
    always_comb begin
        phase_next   = phase_reg;
        id_cnt_next  = id_cnt_reg;
        id_acc_next  = id_acc_reg;
        len_acc_next = len_acc_reg;
        len_grp_next = len_grp_reg;
        skip_next    = skip_reg;
        pos_next     = pos_reg;
        emit         = 1'b0;
        result.result_kind  = tsp_pkg::RK_REGION_END;
        result.field_id     = '0;
        result.value_length = '0;
        result.value_offset = '0;
        result.region_done  = last;

        if (active) begin
            pos_next = pos_inc;
            unique case (phase_reg)
                tsp_pkg::PH_ID: begin
                    id_acc_next = id_acc_reg |
                                  (tsp_pkg::FIELD_ID_W'(data_byte) << {id_cnt_reg[0], 3'b000});
                    id_cnt_next = id_cnt_inc;
                    if (id_cnt_inc >= tsp_pkg::ID_CNT_W'(tsp_pkg::ID_BYTES)) begin
                        phase_next   = tsp_pkg::PH_LEN;
                        len_acc_next = '0;
                        len_grp_next = '0;
                    end
                end
                tsp_pkg::PH_LEN: begin
                    len_acc_next = len_acc_new;
                    if (!data_byte[7]) begin
                        // Header complete.
                        emit                = 1'b1;
                        result.result_kind  = tsp_pkg::RK_HEADER;
                        result.field_id     = id_acc_reg;
                        result.value_length = len_acc_new;
                        result.value_offset = tsp_pkg::OFFSET_W'(base_offset) + pos_inc;
                        skip_next    = len_acc_new;
                        phase_next   = (len_acc_new != '0) ? tsp_pkg::PH_SKIP : tsp_pkg::PH_ID;
                        id_cnt_next  = '0;
                        id_acc_next  = '0;
                        len_acc_next = '0;
                        len_grp_next = '0;
                    end else if (grp_clamp >= tsp_pkg::LEN_LAST_GROUP) begin
                        // Continuation on the fifth length byte.
                        emit               = 1'b1;
                        result.result_kind = tsp_pkg::RK_OVERFLOW;
                        result.field_id    = id_acc_reg;
                        phase_next         = tsp_pkg::PH_ERR;
                    end else begin
                        len_grp_next = grp_clamp + 3'd1;
                    end
                end
                tsp_pkg::PH_SKIP: begin
                    skip_next = skip_dec;
                    if (skip_dec == '0) begin
                        phase_next = tsp_pkg::PH_ID;
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase

            // The region's last byte always yields a beat.
            if (last) begin
                emit = 1'b1;
                if (phase_next != tsp_pkg::PH_ERR) begin
                    phase_next = tsp_pkg::PH_END;
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= tsp_pkg::PH_ID;
            id_cnt_reg  <= '0;
            id_acc_reg  <= '0;
            len_acc_reg <= '0;
            len_grp_reg <= '0;
            skip_reg    <= '0;
            pos_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            id_cnt_reg  <= id_cnt_next;
            id_acc_reg  <= id_acc_next;
            len_acc_reg <= len_acc_next;
            len_grp_reg <= len_grp_next;
            skip_reg    <= skip_next;
            pos_reg     <= pos_next;
        end
    end

endmodule

### sv/tsp_out_buf.sv
// Two-entry result buffer of the TLV stream parser: an output register and
// a skid register between the parser core and the result channel.
// Depends on tsp_pkg.
module tsp_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  tsp_pkg::result_t  push_data,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output tsp_pkg::result_t  m_data
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    tsp_pkg::result_t  out_data_reg, out_data_next;
    tsp_pkg::result_t  skid_data_reg, skid_data_next;
    logic              pop;

    assign pop     = out_valid_reg && m_ready;
    assign space   = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // Move beats forward; a push never arrives while the skid entry is full.
    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (push) begin
                out_data_next = push_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_data_next  = push_data;
                out_valid_next = 1'b1;
            end else begin
                skid_data_next  = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    // Valid flags reset; payload registers do not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

### sv/tlv_stream_parser.sv
// Top level of the TLV stream parser: APB registers, parser core and the
// result buffer. Depends on tsp_pkg, tsp_core and tsp_out_buf.
//
// The parser takes one region byte per beat, one beat per clock, and reports
// each record header (field id, LEB128 length and absolute value offset), a
// length overflow once, and the end of the region. A byte's result is registered
// into the output register, or into the skid register while the output register
// holds an untaken beat. Input is stalled only when both entries of the two-entry
// result buffer are held, so throughput is one byte per clock as long as the
// result side takes a beat whenever one is offered; a stalled result side stops
// input after two pending results. Registers: base_offset at byte address 0,
// region_length at 4. Write them only while the parser is idle.
module tlv_stream_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tsp_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // Byte input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    // Result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [1:0]                        m_result_kind,
    output logic [15:0]                       m_field_id,
    output logic [31:0]                       m_value_length,
    output logic [32:0]                       m_value_offset,
    output logic                              m_region_done
);

    logic [tsp_pkg::REG_W-1:0]  base_offset_reg;
    logic [tsp_pkg::REG_W-1:0]  region_length_reg;
    logic                       cfg_write;
    logic                       byte_fire;
    logic                       core_emit;
    logic                       buf_space;
    tsp_pkg::result_t           core_result;
    tsp_pkg::result_t           out_result;

    // Register file.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_offset_reg   <= '0;
            region_length_reg <= '0;
        end else if (cfg_write) begin
            unique case (paddr[2])
                tsp_pkg::REG_BASE_OFFSET:   base_offset_reg   <= pwdata;
                tsp_pkg::REG_REGION_LENGTH: region_length_reg <= pwdata;
                default: base_offset_reg <= base_offset_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tsp_pkg::REG_BASE_OFFSET:   prdata = base_offset_reg;
            tsp_pkg::REG_REGION_LENGTH: prdata = region_length_reg;
            default:                    prdata = '0;
        endcase
    end

    // Byte channel handshake.
    assign s_ready   = buf_space;
    assign byte_fire = s_valid && s_ready;

    tsp_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_fire     (byte_fire),
        .data_byte     (s_data_byte),
        .base_offset   (base_offset_reg),
        .region_length (region_length_reg),
        .emit          (core_emit),
        .result        (core_result)
    );

    tsp_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (core_emit),
        .push_data (core_result),
        .space     (buf_space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (out_result)
    );

    // Result fields.
    assign m_result_kind  = out_result.result_kind;
    assign m_field_id     = out_result.field_id;
    assign m_value_length = out_result.value_length;
    assign m_value_offset = out_result.value_offset;
    assign m_region_done  = out_result.region_done;

endmodule

### tb/tsp_checker.sv
// Checker for the TLV stream parser: predicts result beats from the accepted
// bytes and APB register writes, then compares every result beat in order.
// Depends on tsp_pkg for the phase, result kind and result beat types.
module tsp_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tsp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [1:0]                     m_result_kind,
    input  logic [15:0]                    m_field_id,
    input  logic [31:0]                    m_value_length,
    input  logic [32:0]                    m_value_offset,
    input  logic                           m_region_done,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Predicted registers and parser state.
    logic [31:0]      base_q;
    logic [31:0]      region_len_q;
    tsp_pkg::phase_t  phase;
    logic [1:0]       id_cnt;
    logic [15:0]      id_acc;
    logic [31:0]      len_acc;
    logic [2:0]       grp_cnt;
    logic [31:0]      skip_left;
    logic [32:0]      rgn_pos;
    logic             sticky_err;

    // Result beats predicted but not yet seen on the result channel.
    tsp_pkg::result_t expected_beats[$];

    int fails = 0;
    assign fail_count = fails;

    task automatic clear_parser();
        base_q       = '0;
        region_len_q = '0;
        phase        = tsp_pkg::PH_ID;
        id_cnt       = '0;
        id_acc       = '0;
        len_acc      = '0;
        grp_cnt      = '0;
        skip_left    = '0;
        rgn_pos      = '0;
        sticky_err   = 1'b0;
    endtask

    // Advance the parser by one byte and queue the result beat it causes.
    task automatic parse_byte(input logic [7:0] b);
        logic [32:0]      pos;
        logic [2:0]       g;
        logic             last;
        logic             emit;
        tsp_pkg::result_t r;
        pos  = rgn_pos;
        emit = 1'b0;
        r    = '0;
        r.result_kind = tsp_pkg::RK_REGION_END;
        if (sticky_err || phase == tsp_pkg::PH_END || phase == tsp_pkg::PH_ERR)
            return;
        if (pos >= {1'b0, region_len_q})
            return;
        last    = (pos + 33'd1) == {1'b0, region_len_q};
        rgn_pos = pos + 33'd1;
        case (phase)
            tsp_pkg::PH_ID: begin
                id_acc = id_acc | (16'(b) << (8 * id_cnt[0]));
                id_cnt = id_cnt + 2'd1;
                if (id_cnt >= tsp_pkg::ID_BYTES) begin
                    phase   = tsp_pkg::PH_LEN;
                    len_acc = '0;
                    grp_cnt = '0;
                end
            end
            tsp_pkg::PH_LEN: begin
                g = (grp_cnt > tsp_pkg::LEN_LAST_GROUP) ? tsp_pkg::LEN_LAST_GROUP : grp_cnt;
                // Payload bits shifted past bit 31 are dropped here.
                len_acc = len_acc | (32'(b[6:0]) << (7 * g));
                if (!b[7]) begin
                    emit           = 1'b1;
                    r.result_kind  = tsp_pkg::RK_HEADER;
                    r.field_id     = id_acc;
                    r.value_length = len_acc;
                    r.value_offset = {1'b0, base_q} + pos + 33'd1;
                    skip_left      = len_acc;
                    phase          = (len_acc != 0) ? tsp_pkg::PH_SKIP : tsp_pkg::PH_ID;
                    id_cnt         = '0;
                    id_acc         = '0;
                    len_acc        = '0;
                    grp_cnt        = '0;
                end else if (g >= tsp_pkg::LEN_LAST_GROUP) begin
                    emit          = 1'b1;
                    r.result_kind = tsp_pkg::RK_OVERFLOW;
                    r.field_id    = id_acc;
                    sticky_err    = 1'b1;
                    phase         = tsp_pkg::PH_ERR;
                end else begin
                    grp_cnt = g + 3'd1;
                end
            end
            default: begin
                skip_left = skip_left - 32'd1;
                if (skip_left == 0)
                    phase = tsp_pkg::PH_ID;
            end
        endcase
        // The region's last byte always reports, even with nothing else to say.
        if (last) begin
            if (phase != tsp_pkg::PH_ERR)
                phase = tsp_pkg::PH_END;
            emit = 1'b1;
        end
        r.region_done = last;
        if (emit)
            expected_beats.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [32:0] want,
                               input logic [32:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    // Compare one result beat with the oldest prediction.
    task automatic check_beat();
        tsp_pkg::result_t e;
        if (expected_beats.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual kind %0d id %0h",
                     $time, m_result_kind, m_field_id);
            fails++;
            return;
        end
        e = expected_beats.pop_front();
        check_field("result_kind", 33'(e.result_kind), 33'(m_result_kind));
        check_field("field_id", 33'(e.field_id), 33'(m_field_id));
        check_field("value_length", 33'(e.value_length), 33'(m_value_length));
        check_field("value_offset", e.value_offset, m_value_offset);
        check_field("region_done", 33'(e.region_done), 33'(m_region_done));
    endtask

    // Watch register writes, input beats and result beats at each edge.
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_parser();
            expected_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == tsp_pkg::REG_BASE_OFFSET)
                    base_q = pwdata;
                else
                    region_len_q = pwdata;
            end
            if (s_valid && s_ready)
                parse_byte(s_data_byte);
            if (m_valid && m_ready)
                check_beat();
        end
        pending <= expected_beats.size();
    end

endmodule

### tb/tb.sv
// Testbench top for the TLV stream parser: clock, reset, APB writes and the
// byte stimulus, plus the verdict. Depends on tsp_pkg, tlv_stream_parser and
// tsp_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [tsp_pkg::APB_ADDR_W-1:0] ADDR_BASE_OFFSET   = 3'd0;
    localparam logic [tsp_pkg::APB_ADDR_W-1:0] ADDR_REGION_LENGTH = 3'd4;
    localparam int PHASE_BYTES = 550;
    localparam int DRAIN_CYCLES = 8;

    // How the single region of the run is brought to its end.
    typedef enum int {
        END_HEADER_CUT,
        END_VALUE_CUT,
        END_HEADER_LAST,
        END_OVERFLOW_LAST,
        END_OVERFLOW_EARLY
    } ending_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [tsp_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [1:0]  m_result_kind;
    logic [15:0] m_field_id;
    logic [31:0] m_value_length;
    logic [32:0] m_value_offset;
    logic        m_region_done;
    int          fail_count;
    int          pending;

    // Stimulus bookkeeping: idle rates, region position and byte count.
    int          send_idle = 34;
    int          recv_idle = 71;
    logic [31:0] region_len_q = '0;
    logic [31:0] rpos = '0;
    int          bytes_sent = 0;

    tlv_stream_parser uut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .m_field_id(m_field_id), .m_value_length(m_value_length),
        .m_value_offset(m_value_offset), .m_region_done(m_region_done)
    );

    tsp_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_kind(m_result_kind),
        .m_field_id(m_field_id), .m_value_length(m_value_length),
        .m_value_offset(m_value_offset), .m_region_done(m_region_done),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // Offer one byte beat, idling at random first, and wait for acceptance.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (rpos < region_len_q)
            rpos = rpos + 32'd1;
        bytes_sent++;
    endtask

    // Stop offering bytes and wait until every predicted beat has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [tsp_pkg::APB_ADDR_W-1:0] addr,
                             input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        if (addr == ADDR_REGION_LENGTH)
            region_len_q = data;
    endtask

    task automatic send_header(input logic [15:0] fid, input logic [7:0] len_byte);
        send_byte(fid[7:0]);
        send_byte(fid[15:8]);
        send_byte(len_byte);
    endtask

    // One well-formed record with a random id, length encoding and value.
    task automatic send_record();
        logic [15:0] fid;
        logic [31:0] vlen;
        logic [7:0]  b;
        int          pick;
        int          groups;
        fid  = 16'($urandom);
        pick = $urandom_range(0, 99);
        vlen = (pick < 4) ? $urandom_range(128, 200) : $urandom_range(0, 6);
        send_byte(fid[7:0]);
        send_byte(fid[15:8]);
        if (pick >= 88) begin
            // Five groups; the top payload bits of the fifth fall past bit 31.
            send_byte(8'h80 | {1'b0, vlen[6:0]});
            repeat (3) send_byte(8'h80);
            send_byte({1'b0, 3'($urandom), 4'h0});
        end else begin
            groups = (vlen < 128) ? 1 : 2;
            if (pick >= 55)
                groups = groups + $urandom_range(0, 5 - groups);
            for (int i = 0; i < groups; i++) begin
                b = 8'((vlen >> (7 * i)) & 32'h7F);
                if (i < groups - 1)
                    b[7] = 1'b1;
                send_byte(b);
            end
        end
        repeat (vlen) send_byte(8'($urandom));
    endtask

    task automatic random_phase(input int s_idle, input int r_idle, input logic [31:0] base);
        int start;
        int recs;
        wait_drained();
        reg_write(ADDR_BASE_OFFSET, base);
        send_idle = s_idle;
        recv_idle = r_idle;
        start = bytes_sent;
        recs  = 0;
        while (bytes_sent - start < PHASE_BYTES) begin
            // After the twentieth record, hold the stream once until the result side catches up.
            if (recs == 20)
                wait_drained();
            send_record();
            recs++;
        end
    endtask

    // Close the region in one of the ways it can end.
    task automatic finish_region();
        ending_t     how;
        logic [15:0] fid;
        how = ending_t'($urandom_range(0, 4));
        fid = 16'($urandom);
        wait_drained();
        case (how)
            END_HEADER_CUT: begin
                reg_write(ADDR_REGION_LENGTH, rpos + 32'($urandom_range(1, 3)));
                send_header(fid, 8'h85);
                send_byte(8'h01);
            end
            END_VALUE_CUT: begin
                reg_write(ADDR_REGION_LENGTH, rpos + 32'd4 + 32'($urandom_range(1, 5)));
                send_header(fid, 8'hC8);
                send_byte(8'h01);
                repeat (8) send_byte(8'($urandom));
            end
            END_HEADER_LAST: begin
                reg_write(ADDR_REGION_LENGTH, rpos + 32'd3);
                send_header(fid, 8'h03);
                repeat (3) send_byte(8'($urandom));
            end
            END_OVERFLOW_LAST: begin
                reg_write(ADDR_REGION_LENGTH, rpos + 32'd7);
                send_byte(fid[7:0]);
                send_byte(fid[15:8]);
                repeat (5) send_byte(8'h80 | 8'($urandom));
                repeat (2) send_byte(8'($urandom));
            end
            default: begin
                send_byte(fid[7:0]);
                send_byte(fid[15:8]);
                repeat (5) send_byte(8'h80 | 8'($urandom));
                // Sticky error: everything after this is ignored.
                repeat (5) send_byte(8'($urandom));
            end
        endcase
    endtask

    // Main sequence.
    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty region: bytes are dropped without a result.
        repeat (3) send_byte(8'($urandom));
        wait_drained();
        reg_write(ADDR_BASE_OFFSET, 32'h0);
        reg_write(ADDR_REGION_LENGTH, 32'hFFFF_FFFF);
        rpos = '0;

        // Directed records: zero lengths, all-ones id, padded and truncated lengths.
        send_header(16'h0000, 8'h00);
        send_header(16'hFFFF, 8'h80);
        send_byte(8'h00);
        send_header(16'h1234, 8'h83);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hAA);
        send_header(16'hCDAB, 8'h81);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h70);
        send_byte(8'h55);

        // Region shrunk to the current position: bytes are ignored.
        wait_drained();
        reg_write(ADDR_REGION_LENGTH, rpos);
        send_byte(8'h7F);
        send_byte(8'hFF);
        wait_drained();
        reg_write(ADDR_REGION_LENGTH, 32'hFFFF_FFFF);

        random_phase(34, 71, 32'hFFFF_FFFF);
        random_phase(71, 34, 32'($urandom));
        random_phase(0, 0, 32'h8000_0000);

        finish_region();
        wait_drained();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog.
    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
